@@ hw/rtl/status_frame_parser_top_assert.svh @@
// ----------------------------------------------------------------------------
// status frame parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STATUS_FRAME_PARSER_TOP_ASSERT_SVH
`define STATUS_FRAME_PARSER_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define SFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfp check failed");

// next-cycle implication, held off during reset
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfp check failed");

`endif

@@ hw/rtl/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// types and constants of the status frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam int unsigned MIN_FRAME_BYTES = 16;
	localparam logic [7:0] SHORT_LIMIT = 8'(MIN_FRAME_BYTES - 1);
	localparam logic [7:0] POS_MAX = 8'hFF;

	localparam logic [7:0] POS_HEADER = 8'd0;
	localparam logic [7:0] POS_MARKER = 8'd2;
	localparam logic [7:0] POS_MSG_ID = 8'd3;
	localparam logic [7:0] POS_TYPE_HI = 8'd6;
	localparam logic [7:0] POS_TYPE_LO = 8'd7;
	localparam logic [7:0] POS_STATUS = 8'd8;
	localparam logic [7:0] POS_MODE = 8'd9;
	localparam logic [7:0] POS_BATTERY = 8'd10;

	localparam logic [7:0] HEADER_BYTE = 8'hAA;
	localparam logic [7:0] MARKER_BYTE = 8'h1E;
	localparam logic [7:0] MSG_ID_BYTE = 8'h16;
	localparam logic [7:0] TYPE_HI_BYTE = 8'h00;
	localparam logic [7:0] TYPE_LO_BYTE = 8'h0B;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_HEADER   = 3'd2,
		ERR_MARKER   = 3'd3,
		ERR_MSG_ID   = 3'd4,
		ERR_TYPE     = 3'd5,
		ERR_CHECKSUM = 3'd6
	} err_code_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic       frame_ok;
		logic [2:0] error_code;
		logic [1:0] charge_source;
		logic       charging;
		logic       mowing;
		logic [6:0] battery_percent;
		logic [2:0] system_mode;
	} status_item_t;

	typedef struct packed {
		logic advance;
		logic load;
	} core_ctrl_t;

endpackage

@@ hw/rtl/sfp_in_stage.sv @@
// ----------------------------------------------------------------------------
// sfp_in_stage
// input register of the byte channel
// ----------------------------------------------------------------------------
module sfp_in_stage import sfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  byte_item_t byte_item,
	output logic       byte_stall,
	input  core_ctrl_t ctrl,
	output logic       valid_s1,
	output byte_item_t item_s1
);

	assign byte_stall = valid_s1 && !ctrl.advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

endmodule

@@ hw/rtl/sfp_core.sv @@
// ----------------------------------------------------------------------------
// sfp_core
// frame state, header checks and status decode for one item
// ----------------------------------------------------------------------------
module sfp_core import sfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s1,
	input  byte_item_t   item_s1,
	input  logic         out_free,
	output core_ctrl_t   ctrl,
	output status_item_t result
);

	logic [7:0] pos_q;
	logic [7:0] sum_q;
	err_code_t  err_q;
	logic [1:0] charge_q;
	logic       mow_q;
	logic [2:0] mode_q;
	logic [6:0] batt_q;

	err_code_t  hit;
	err_code_t  code;
	logic [7:0] b;

	assign b = item_s1.byte_value;

	always_comb begin
		ctrl.advance = valid_s1 && (!item_s1.last_byte || out_free);
		ctrl.load = valid_s1 && item_s1.last_byte && out_free;
	end

	always_comb begin
		hit = ERR_OK;
		case (pos_q)
			POS_HEADER:  if (b != HEADER_BYTE) hit = ERR_HEADER;
			POS_MARKER:  if (b != MARKER_BYTE) hit = ERR_MARKER;
			POS_MSG_ID:  if (b != MSG_ID_BYTE) hit = ERR_MSG_ID;
			POS_TYPE_HI: if (b != TYPE_HI_BYTE) hit = ERR_TYPE;
			POS_TYPE_LO: if (b != TYPE_LO_BYTE) hit = ERR_TYPE;
			default:     hit = ERR_OK;
		endcase
	end

	always_comb begin
		if (pos_q < SHORT_LIMIT) begin
			code = ERR_SHORT;
		end else if (err_q != ERR_OK) begin
			code = err_q;
		end else if (~sum_q != b) begin
			code = ERR_CHECKSUM;
		end else begin
			code = ERR_OK;
		end
		result = '0;
		result.error_code = code;
		if (code == ERR_OK) begin
			result.frame_ok = 1'b1;
			result.charge_source = charge_q;
			result.charging = (charge_q != 2'd0);
			result.mowing = mow_q;
			result.battery_percent = batt_q;
			result.system_mode = mode_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			err_q <= ERR_OK;
			charge_q <= '0;
			mow_q <= 1'b0;
			mode_q <= '0;
			batt_q <= '0;
		end else if (ctrl.advance) begin
			if (item_s1.last_byte) begin
				pos_q <= '0;
				sum_q <= '0;
				err_q <= ERR_OK;
				charge_q <= '0;
				mow_q <= 1'b0;
				mode_q <= '0;
				batt_q <= '0;
			end else begin
				if (err_q == ERR_OK) begin
					err_q <= hit;
				end
				if (pos_q == POS_STATUS) begin
					charge_q <= b[1:0];
					mow_q <= b[5];
				end
				if (pos_q == POS_MODE) begin
					mode_q <= b[2:0];
				end
				if (pos_q == POS_BATTERY) begin
					batt_q <= b[6:0];
				end
				sum_q <= sum_q + b;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 8'd1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/sfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// sfp_out_stage
// result register of the status channel
// ----------------------------------------------------------------------------
module sfp_out_stage import sfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  core_ctrl_t   ctrl,
	input  status_item_t result,
	output logic         out_free,
	output logic         status_valid,
	output status_item_t status_item,
	input  logic         status_stall
);

	assign out_free = !status_valid || !status_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid <= 1'b0;
		end else if (out_free) begin
			status_valid <= ctrl.load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			status_item <= result;
		end
	end

endmodule

@@ hw/rtl/status_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// status_frame_parser_top
// checks a status frame byte by byte and decodes its status fields
//
// byte channel: byte_valid, byte_stall, byte_item (byte and final-byte flag)
// status channel: status_valid, status_stall, status_item, one item per frame
// one byte is taken every cycle while byte_stall is low; the frame result goes from
// the final byte through the input register and the result register
// bytes before the final one keep flowing while a result waits
// a stalled result holds; a final byte behind it waits in the input register
// reset clears the frame state and empties both registers
// ----------------------------------------------------------------------------
module status_frame_parser_top import sfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	output logic         byte_stall,
	input  byte_item_t   byte_item,
	output logic         status_valid,
	input  logic         status_stall,
	output status_item_t status_item
);

	logic         valid_s1;
	byte_item_t   item_s1;
	logic         out_free;
	core_ctrl_t   ctrl;
	status_item_t result;

	sfp_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.byte_stall (byte_stall),
		.ctrl       (ctrl),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	sfp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.ctrl     (ctrl),
		.result   (result)
	);

	sfp_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.result       (result),
		.out_free     (out_free),
		.status_valid (status_valid),
		.status_item  (status_item),
		.status_stall (status_stall)
	);

endmodule

@@ hw/rtl/sfp_assert_chk.sv @@
// ----------------------------------------------------------------------------
// sfp_assert_chk
// port checks of the status frame parser
// ----------------------------------------------------------------------------
`include "status_frame_parser_top_assert.svh"

module sfp_assert_chk import sfp_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         byte_stall,
	input logic         status_valid,
	input logic         status_stall,
	input status_item_t status_item
);

	logic bad_frame;
	logic fields_zero;

	assign bad_frame = status_valid && !status_item.frame_ok;
	assign fields_zero = (status_item.charge_source == 2'd0) && !status_item.charging &&
		!status_item.mowing && (status_item.battery_percent == 7'd0) &&
		(status_item.system_mode == 3'd0);

	`SFP_ASSERT_IMPLY(a_ok_matches_code, clk, arst_n, status_valid,
		status_item.frame_ok == (status_item.error_code == ERR_OK))
	`SFP_ASSERT_IMPLY(a_bad_fields_zero, clk, arst_n, bad_frame, fields_zero)
	`SFP_ASSERT_IMPLY(a_charging_rule, clk, arst_n, status_valid,
		status_item.charging == (status_item.charge_source != 2'd0))
	`SFP_ASSERT_NEXT(a_stalled_item_holds, clk, arst_n, status_valid && status_stall,
		status_valid && $stable(status_item))
	`SFP_ASSERT_IMPLY(a_stall_behind_result, clk, arst_n, byte_stall,
		status_valid && status_stall)

endmodule

bind status_frame_parser_top sfp_assert_chk u_sfp_assert_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_stall   (byte_stall),
	.status_valid (status_valid),
	.status_stall (status_stall),
	.status_item  (status_item)
);

@@ sim/tb_status_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_status_frame_parser_top
// self-checking bench for the status frame parser: byte items go in through
// valid/stall, a predictor works out each frame result and a scoreboard
// compares every status item field by field, under random idling and stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_status_frame_parser_top import sfp_pkg::*;;

	class status_scoreboard;
		logic [7:0] byte_pos;
		logic [7:0] sum;
		err_code_t first_err;
		logic [1:0] charge_bits;
		logic mow_bit;
		logic [2:0] mode_bits;
		logic [6:0] battery_bits;
		status_item_t expected_status[$];
		int mismatches;

		function new();
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_pos = 8'd0;
			sum = 8'd0;
			first_err = ERR_OK;
			charge_bits = 2'd0;
			mow_bit = 1'b0;
			mode_bits = 3'd0;
			battery_bits = 7'd0;
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			mismatches++;
		endtask

		function void latch_error(err_code_t code);
			if (first_err == ERR_OK)
				first_err = code;
		endfunction

		function void take_byte(byte_item_t it);
			status_item_t res;
			err_code_t code;
			int unsigned frame_len;
			logic [7:0] b;
			b = it.byte_value;
			if (!it.last_byte) begin
				case (byte_pos)
					POS_HEADER: if (b != HEADER_BYTE) latch_error(ERR_HEADER);
					POS_MARKER: if (b != MARKER_BYTE) latch_error(ERR_MARKER);
					POS_MSG_ID: if (b != MSG_ID_BYTE) latch_error(ERR_MSG_ID);
					POS_TYPE_HI: if (b != TYPE_HI_BYTE) latch_error(ERR_TYPE);
					POS_TYPE_LO: if (b != TYPE_LO_BYTE) latch_error(ERR_TYPE);
					POS_STATUS: begin
						charge_bits = b[1:0];
						mow_bit = b[5];
					end
					POS_MODE: mode_bits = b[2:0];
					POS_BATTERY: battery_bits = b[6:0];
					default: ;
				endcase
				sum = sum + b;
				if (byte_pos != POS_MAX)
					byte_pos = byte_pos + 8'd1;
			end else begin
				frame_len = int'(byte_pos) + 1;
				if (frame_len < MIN_FRAME_BYTES)
					code = ERR_SHORT;
				else if (first_err != ERR_OK)
					code = first_err;
				else if (~sum != b)
					code = ERR_CHECKSUM;
				else
					code = ERR_OK;
				res = '0;
				res.error_code = code;
				if (code == ERR_OK) begin
					res.frame_ok = 1'b1;
					res.charge_source = charge_bits;
					res.charging = (charge_bits != 2'd0);
					res.mowing = mow_bit;
					res.battery_percent = battery_bits;
					res.system_mode = mode_bits;
				end
				expected_status.push_back(res);
				clear_frame();
			end
		endfunction

		task check_field(string what, int got, int want);
			if (got !== want)
				report(what, got, want);
		endtask

		task check_status(status_item_t got);
			status_item_t want;
			if (expected_status.size() == 0) begin
				report("unexpected status item", int'(got), 0);
				return;
			end
			want = expected_status.pop_front();
			check_field("frame_ok", int'(got.frame_ok), int'(want.frame_ok));
			check_field("error_code", int'(got.error_code), int'(want.error_code));
			check_field("charge_source", int'(got.charge_source), int'(want.charge_source));
			check_field("charging", int'(got.charging), int'(want.charging));
			check_field("mowing", int'(got.mowing), int'(want.mowing));
			check_field("battery_percent", int'(got.battery_percent),
				int'(want.battery_percent));
			check_field("system_mode", int'(got.system_mode), int'(want.system_mode));
		endtask

		function int pending();
			return expected_status.size();
		endfunction

		task flag_leftover();
			while (expected_status.size() != 0) begin
				report("missing status item", 0, int'(expected_status[0].error_code));
				void'(expected_status.pop_front());
			end
		endtask
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	byte_item_t byte_item = '0;
	logic status_valid;
	logic status_stall = 1'b0;
	status_item_t status_item;

	status_scoreboard board = new();
	int items_sent = 0;
	bit quiet = 1'b0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	status_frame_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.status_valid(status_valid),
		.status_stall(status_stall),
		.status_item(status_item)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver stall, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 300;
			status_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			status_stall <= 1'b1;
		end else if (quiet) begin
			status_stall <= 1'b0;
		end else begin
			status_stall <= ($urandom_range(99) < 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && status_valid && !status_stall)
			board.check_status(status_item);
	end

	task send_byte(input logic [7:0] value, input logic last);
		if (!quiet && $urandom_range(99) < 12) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= '{byte_value: value, last_byte: last};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		board.take_byte('{byte_value: value, last_byte: last});
		items_sent++;
	endtask

	// fill < 0 gives random free bytes; flaw < 0 leaves the fixed bytes intact
	task send_frame(input int len, input int fill, input int flaw_a, input int flaw_b,
			input bit sum_ok, input bit noise);
		logic [7:0] frame[];
		logic [7:0] acc;
		frame = new[len];
		acc = 8'd0;
		for (int i = 0; i < len; i++)
			frame[i] = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
		if (!noise) begin
			if (len > 0) frame[0] = HEADER_BYTE;
			if (len > 2) frame[2] = MARKER_BYTE;
			if (len > 3) frame[3] = MSG_ID_BYTE;
			if (len > 6) frame[6] = TYPE_HI_BYTE;
			if (len > 7) frame[7] = TYPE_LO_BYTE;
			if (flaw_a >= 0 && flaw_a < len)
				frame[flaw_a] = frame[flaw_a] ^ 8'($urandom_range(1, 255));
			if (flaw_b >= 0 && flaw_b < len)
				frame[flaw_b] = frame[flaw_b] ^ 8'($urandom_range(1, 255));
			for (int i = 0; i < len - 1; i++)
				acc = acc + frame[i];
			if (sum_ok)
				frame[len - 1] = ~acc;
		end
		for (int i = 0; i < len; i++)
			send_byte(frame[i], i == len - 1);
	endtask

	task wait_drained();
		int waited;
		waited = 0;
		byte_valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (board.pending() != 0 && waited < 100000);
	endtask

	task send_random_frame();
		int fixed_pos[5];
		int r;
		int len;
		int flaw_a;
		int flaw_b;
		fixed_pos = '{0, 2, 3, 6, 7};
		r = $urandom_range(99);
		if (r < 8)
			len = $urandom_range(1, 11);
		else if (r < 18)
			len = $urandom_range(12, 15);
		else
			len = $urandom_range(16, 24);
		flaw_a = ($urandom_range(99) < 25) ? fixed_pos[$urandom_range(4)] : -1;
		flaw_b = ($urandom_range(99) < 10) ? fixed_pos[$urandom_range(4)] : -1;
		send_frame(len, -1, flaw_a, flaw_b, $urandom_range(99) < 80,
			$urandom_range(99) < 10);
	endtask

	initial begin
		int frames;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// good frame with all status bits set, then a lone final byte
		send_frame(16, 8'hFF, -1, -1, 1'b1, 1'b0);
		send_frame(1, 8'hFF, -1, -1, 1'b0, 1'b1);
		wait_drained();

		frames = 0;
		while (items_sent < 1350) begin
			if (frames == 20)
				hold_req++;
			if (frames == 30)
				send_frame($urandom_range(256, 300), -1, -1, -1, 1'b1, 1'b0);
			if (frames == 40)
				wait_drained();
			quiet = (frames >= 50 && frames < 62);
			send_random_frame();
			frames++;
		end
		quiet = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		board.flag_leftover();
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_in_stage.sv
hw/rtl/sfp_core.sv
hw/rtl/sfp_out_stage.sv
hw/rtl/status_frame_parser_top.sv
hw/rtl/sfp_assert_chk.sv
sim/tb_status_frame_parser_top.sv
